// ===== rtl/core/length_prefixed_frame_deframer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// length prefixed frame deframer assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, idle during reset
`define LPFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define LPFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPFD_ASSERT_IMP(label, ante, cons, msg)
`define LPFD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// shared types and constants of the length prefixed frame deframer
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned DONE_W   = COUNT_W + 1;

    // result kinds
    localparam logic KIND_BODY      = 1'b0;
    localparam logic KIND_HEARTBEAT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  body_byte;
        logic [LEN_W-1:0]   frame_length;
        logic               is_last;
    } lpfd_result_t;

    typedef struct packed {
        logic has_result;
        logic in_body;
    } lpfd_status_t;

endpackage

// ===== rtl/core/length_prefixed_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// splits a byte stream with big-endian length headers into body byte beats
// ----------------------------------------------------------------------------
// usage
//   input channel: one stream byte per beat on rx_byte, in_valid / in_stall
//   output channel: kind, body_byte, frame_length, is_last per beat,
//   out_valid / out_stall
//   a header of HEADER_BYTES bytes, most significant first, gives the length
//   a zero length yields one heartbeat beat (kind high, is_last high)
//   a nonzero length passes the next bytes out, each with the length,
//   the final one flagged by is_last; header bytes give no output beat
// timing
//   one byte per cycle sustained while out_stall is low; a body byte or
//   heartbeat passes through the input register and then the result register
// reset
//   rst_n clears the header count, length and byte countdown at once;
//   the block is ready for a header in the first cycle after reset
// stalling
//   a held result waits in the result register; header bytes keep being
//   absorbed, and in_stall rises only when a result-bearing byte is blocked
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_unit_assert.svh"

module length_prefixed_frame_deframer_unit
#(
    parameter int unsigned HEADER_BYTES = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lpfd_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [lpfd_pkg::BYTE_W-1:0] body_byte,
    output logic [lpfd_pkg::LEN_W-1:0]  frame_length,
    output logic                        is_last
);
    import lpfd_pkg::*;

    // input register
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;

    // parser
    lpfd_result_t      result;
    lpfd_status_t      status;

    // result register
    logic              out_free;
    lpfd_result_t      out_res;

    // a held byte is consumed when its result has room, or it has no result
    logic              take;
    logic              out_load;

    assign take     = held_valid && (out_free || !status.has_result);
    assign out_load = take && status.has_result;

    lpfd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    lpfd_parse
    #(
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cur_byte (held_byte),
        .take     (take),
        .result   (result),
        .status   (status)
    );

    lpfd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .result    (result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .held      (out_res)
    );

    assign kind         = out_res.kind;
    assign body_byte    = out_res.body_byte;
    assign frame_length = out_res.frame_length;
    assign is_last      = out_res.is_last;

    // checks

    // a byte is never consumed over a result that could not be stored
    `LPFD_ASSERT_IMP(a_no_lost_result, take && !out_free, !status.has_result, "result dropped")

    // heartbeats only come out of header collection
    `LPFD_ASSERT_IMP(a_heartbeat_in_header, status.in_body && held_valid,
        result.kind == KIND_BODY, "heartbeat during body")

    // the final body byte returns the parser to header collection
    `LPFD_ASSERT_NXT(a_last_ends_body,
        out_load && status.in_body && result.is_last,
        !status.in_body, "body not closed after last byte")

    // upstream only sees stall while a byte is actually held
    `LPFD_ASSERT_IMP(a_stall_needs_byte, in_stall, held_valid && status.has_result,
        "spurious input stall")

endmodule

// ===== rtl/core/lpfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// lpfd_in_stage
// input register for received bytes, stalls upstream while a held beat is not taken
// ----------------------------------------------------------------------------
module lpfd_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lpfd_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        take,
    output logic                        held_valid,
    output logic [lpfd_pkg::BYTE_W-1:0] held_byte
);
    import lpfd_pkg::*;

    logic              vld_reg;
    logic              vld_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              load;

    assign in_stall = vld_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = vld_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== rtl/core/lpfd_parse.sv =====
// ----------------------------------------------------------------------------
// lpfd_parse
// header gathering and body countdown state, one byte per cycle while take is high
// ----------------------------------------------------------------------------
module lpfd_parse
#(
    parameter int unsigned HEADER_BYTES = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lpfd_pkg::BYTE_W-1:0] cur_byte,
    input  logic                        take,
    output lpfd_pkg::lpfd_result_t      result,
    output lpfd_pkg::lpfd_status_t      status
);
    import lpfd_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [LEN_W-1:0]   accum_reg;
    logic [LEN_W-1:0]   accum_next;
    logic [LEN_W-1:0]   left_reg;
    logic [LEN_W-1:0]   left_next;

    logic               in_body;
    logic [LEN_W-1:0]   accum_hdr;
    logic [COUNT_W-1:0] count_inc;
    logic [DONE_W-1:0]  done_cnt;
    logic               hdr_done;
    logic               has_result;

    assign in_body   = (left_reg != '0);
    assign accum_hdr = (count_reg == '0) ? {{(LEN_W-BYTE_W){1'b0}}, cur_byte}
                                         : {accum_reg[LEN_W-BYTE_W-1:0], cur_byte};
    assign count_inc = count_reg + COUNT_W'(1);
    // a wrapped count means eight bytes gathered
    assign done_cnt  = (count_inc == '0) ? DONE_W'(8) : {1'b0, count_inc};
    assign hdr_done  = (done_cnt >= DONE_W'(HEADER_BYTES));

    always_comb
    begin
        count_next = count_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        has_result = 1'b0;
        result     = '0;
        if (in_body)
        begin
            has_result          = 1'b1;
            result.kind         = KIND_BODY;
            result.body_byte    = cur_byte;
            result.frame_length = accum_reg;
            result.is_last      = (left_reg == LEN_W'(1));
            left_next           = left_reg - LEN_W'(1);
        end
        else
        begin
            accum_next = accum_hdr;
            count_next = count_inc;
            if (hdr_done)
            begin
                count_next = '0;
                if (accum_hdr == '0)
                begin
                    has_result     = 1'b1;
                    result.kind    = KIND_HEARTBEAT;
                    result.is_last = 1'b1;
                end
                else
                begin
                    left_next = accum_hdr;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            accum_reg <= '0;
            left_reg  <= '0;
        end
        else if (take)
        begin
            count_reg <= count_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
        end
    end

    assign status.has_result = has_result;
    assign status.in_body    = in_body;

endmodule

// ===== rtl/core/lpfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// lpfd_out_stage
// result register towards the receiver, refills in the cycle it drains
// ----------------------------------------------------------------------------
module lpfd_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  lpfd_pkg::lpfd_result_t result,
    output logic                   free,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lpfd_pkg::lpfd_result_t held
);
    import lpfd_pkg::*;

    logic         vld_reg;
    logic         vld_next;
    lpfd_result_t res_reg;

    assign free = !vld_reg || !out_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (vld_reg && !out_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = vld_reg;
    assign held      = res_reg;

endmodule
